// ===== hw/rtl/sha256_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 stream hasher.
package sha256_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned Rounds = 64;

    typedef logic [WordW-1:0] t_word;
    typedef logic [7:0]       t_byte;
    typedef logic [2:0]       t_widx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_WB,
        S_ORD,
        S_OCAP,
        S_OWAIT
    } t_state;

    localparam t_word IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K_ROUND [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_byte PAD_MARK = 8'h80;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== hw/rtl/sha256_if.sv =====
// Stream interfaces of the SHA-256 hasher: message bytes in, digest words out.
interface sha256_byte_if;
    import sha256_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sha256_word_if;
    import sha256_pkg::*;

    logic  valid;
    logic  ready;
    t_word digest_word;
    t_widx word_index;
    logic  last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ===== hw/rtl/sha256_stream_hasher.sv =====
// SHA-256 hasher over a byte stream with a block buffer and a chaining-state memory.
//
//   channel   | dir | transfer moves
//   ----------+-----+--------------------------------------------
//   i_byte    | in  | data_byte, last_byte (one message byte)
//   o_digest  | out | digest_word, word_index, last_word
//
// Bytes are taken one per cycle while the 64-byte block fills; a full block then
// holds the input through the state loads, the rounds (with each schedule word
// registered ahead of its round) and the write-backs.
// After a last byte, padding writes up to 16 words, one or two blocks compress,
// and each digest word is read, captured and then held until taken; no byte is taken then.
// Reset is synchronous and active low; no clearing pass is needed.
module sha256_stream_hasher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sha256_byte_if.sink          i_byte,
    sha256_word_if.source        o_digest
);
    import sha256_pkg::*;

    t_word bf_mem [16];
    t_word ch_mem [8];

    t_state      r_state, n_state;
    logic [63:0] r_cnt;
    logic [6:0]  r_ctr;
    logic [3:0]  r_q;
    t_widx       r_oidx;
    logic        r_iv;
    logic        r_msg_end;
    logic        r_in_pad;
    logic        r_mark;
    logic        r_len_here;

    t_word       r_word;
    t_word       r_bf_q;
    t_word       r_ch_q;
    t_widx       r_ch_raddr;
    t_word       r_v [8];
    t_word       r_w [16];
    t_word       r_wk;
    t_word       r_out_word;

    logic        bf_we;
    logic [3:0]  bf_waddr;
    logic [3:0]  bf_raddr;
    t_word       bf_wdata;
    logic        ch_we;
    t_widx       ch_waddr;
    t_widx       ch_raddr;
    t_word       ch_wdata;

    logic        in_xfer;
    logic        out_xfer;
    logic        blk_full;
    logic [63:0] n_cnt;
    t_word       n_word;
    t_word       ch_rdata;
    t_word       mark_word;
    t_word       pad_word;
    t_word       w_new;
    t_widx       ctr_m1;
    t_word       t1;
    t_word       t2;

    assign in_xfer  = i_byte.valid && i_byte.ready;
    assign out_xfer = o_digest.valid && o_digest.ready;
    assign blk_full = (r_cnt[5:0] == 6'd63);
    assign n_cnt    = r_cnt + 64'd1;
    assign n_word   = {r_word[23:0], i_byte.data_byte};
    assign ch_rdata = r_iv ? IV[r_ch_raddr] : r_ch_q;
    assign ctr_m1   = r_ctr[2:0] - 3'd1;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    mark_word = {PAD_MARK, 24'h0};
            2'd1:    mark_word = {r_word[7:0], PAD_MARK, 16'h0};
            2'd2:    mark_word = {r_word[15:0], PAD_MARK, 8'h0};
            default: mark_word = {r_word[23:0], PAD_MARK};
        endcase
    end

    always_comb begin
        if (r_mark && (r_q == r_cnt[5:2])) begin
            pad_word = mark_word;
        end else if (r_len_here && (r_q == 4'd14)) begin
            pad_word = r_cnt[60:29];
        end else if (r_len_here && (r_q == 4'd15)) begin
            pad_word = {r_cnt[28:0], 3'b000};
        end else begin
            pad_word = '0;
        end
    end

    assign w_new = (r_ctr < 7'd16) ? r_bf_q
                 : small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];

    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + r_wk;
    assign t2 = big_sigma0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (blk_full) begin
                        n_state = S_LOAD;
                    end else if (i_byte.last_byte) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_q == 4'd15) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_ctr == 7'd8) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_ctr == 7'd64) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (r_ctr == 7'd8) begin
                    if (!r_msg_end) begin
                        n_state = S_IDLE;
                    end else if (r_in_pad && r_len_here) begin
                        n_state = S_ORD;
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ORD:   n_state = S_OCAP;
            S_OCAP:  n_state = S_OWAIT;
            S_OWAIT: begin
                if (out_xfer) begin
                    n_state = (r_oidx == 3'd7) ? S_IDLE : S_ORD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        bf_we          = 1'b0;
        bf_waddr       = r_cnt[5:2];
        bf_wdata       = n_word;
        bf_raddr       = 4'd0;
        ch_we          = 1'b0;
        ch_waddr       = ctr_m1;
        ch_wdata       = ch_rdata + r_v[ctr_m1];
        ch_raddr       = r_ctr[2:0];
        i_byte.ready   = 1'b0;
        o_digest.valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_byte.ready = 1'b1;
                bf_we        = in_xfer && (r_cnt[1:0] == 2'd3);
            end
            S_PAD: begin
                bf_we    = 1'b1;
                bf_waddr = r_q;
                bf_wdata = pad_word;
            end
            S_ROUND: begin
                bf_raddr = r_ctr[3:0] + 4'd1;
            end
            S_WB: begin
                ch_we = (r_ctr != 7'd0);
            end
            S_ORD: begin
                ch_raddr = r_oidx;
            end
            S_OWAIT: begin
                o_digest.valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_digest.digest_word = r_out_word;
    assign o_digest.word_index  = r_oidx;
    assign o_digest.last_word   = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (bf_we) begin
            bf_mem[bf_waddr] <= bf_wdata;
        end
        r_bf_q <= bf_mem[bf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ch_we) begin
            ch_mem[ch_waddr] <= ch_wdata;
        end
        r_ch_q     <= ch_mem[ch_raddr];
        r_ch_raddr <= ch_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_ctr      <= '0;
            r_q        <= '0;
            r_oidx     <= '0;
            r_iv       <= 1'b1;
            r_msg_end  <= 1'b0;
            r_in_pad   <= 1'b0;
            r_mark     <= 1'b0;
            r_len_here <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ctr   <= (n_state != r_state) ? 7'd0 : r_ctr + 7'd1;
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cnt     <= n_cnt;
                        r_msg_end <= i_byte.last_byte;
                        if (i_byte.last_byte && !blk_full) begin
                            r_in_pad   <= 1'b1;
                            r_mark     <= 1'b1;
                            r_q        <= n_cnt[5:2];
                            r_len_here <= (n_cnt[5:0] < 6'd56);
                        end
                    end
                end
                S_PAD: begin
                    r_q <= r_q + 4'd1;
                end
                S_WB: begin
                    if (r_ctr == 7'd8) begin
                        r_iv <= 1'b0;
                        if (r_msg_end && !r_in_pad) begin
                            r_in_pad   <= 1'b1;
                            r_mark     <= 1'b1;
                            r_q        <= r_cnt[5:2];
                            r_len_here <= (r_cnt[5:0] < 6'd56);
                        end else if (r_msg_end && !r_len_here) begin
                            r_mark     <= 1'b0;
                            r_q        <= 4'd0;
                            r_len_here <= 1'b1;
                        end
                    end
                end
                S_OWAIT: begin
                    if (out_xfer) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_cnt      <= '0;
                            r_iv       <= 1'b1;
                            r_msg_end  <= 1'b0;
                            r_in_pad   <= 1'b0;
                            r_mark     <= 1'b0;
                            r_len_here <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && in_xfer) begin
            r_word <= n_word;
        end
        if ((r_state == S_LOAD) && (r_ctr != 7'd0)) begin
            r_v[ctr_m1] <= ch_rdata;
        end
        if (r_state == S_ROUND) begin
            if (r_ctr < 7'd64) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[15] <= w_new;
                r_wk    <= w_new + K_ROUND[r_ctr[5:0]];
            end
            if (r_ctr != 7'd0) begin
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
        end
        if (r_state == S_OCAP) begin
            r_out_word <= ch_rdata;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_byte.ready && o_digest.valid))
        else $error("byte input open while a digest word is pending");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_digest.last_word) |=> (i_byte.ready && !r_iv == 1'b0))
        else $error("hasher did not return to initial state after the digest");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_ctr <= 7'd64))
        else $error("round counter ran past the last round");

    a_ch_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ch_we |-> (ch_waddr != ch_raddr))
        else $error("chaining-state write and read hit the same entry");

endmodule

// ===== sim/tb_sha256_stream_hasher.sv =====
// Self-checking testbench of the SHA-256 stream hasher with its own digest predictor.
module tb_sha256_stream_hasher;
    import sha256_pkg::*;

    localparam int unsigned IdleLimit  = 5000;
    localparam int unsigned HoldCycles = 250;
    localparam int unsigned TailCycles = 200;

    localparam t_word HashInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        t_word word;
        t_widx idx;
        logic  last;
    } t_digest_item;

    logic i_clk;
    logic i_rst_n;

    sha256_byte_if byte_if ();
    sha256_word_if digest_if ();

    sha256_stream_hasher i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .o_digest (digest_if)
    );

    t_word        hash_chain [8];
    logic [63:0]  hash_len;
    t_byte        hash_block [64];
    t_digest_item digest_words_due [$];
    t_digest_item due_item;

    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned messages_sent;
    int unsigned bytes_sent;
    int unsigned idle_cycles;
    bit          no_idle;
    bit          hold_req;

    function automatic t_word ror32(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_hash_block();
        t_word w [64];
        t_word v [8];
        t_word t1;
        t_word t2;
        for (int r = 0; r < 16; r++) begin
            w[r] = {hash_block[4*r], hash_block[4*r+1], hash_block[4*r+2], hash_block[4*r+3]};
        end
        for (int r = 16; r < 64; r++) begin
            w[r] = (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                 + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
        end
        v = hash_chain;
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            hash_chain[i] = hash_chain[i] + v[i];
        end
    endfunction

    function automatic void absorb_byte(input t_byte b, input logic last);
        logic [63:0] bit_len;
        int          pos;
        t_digest_item item;
        hash_block[hash_len[5:0]] = b;
        hash_len = hash_len + 1;
        if (hash_len[5:0] == 6'd0) begin
            compress_hash_block();
        end
        if (!last) begin
            return;
        end
        bit_len = hash_len << 3;
        pos = int'(hash_len[5:0]);
        hash_block[pos] = 8'h80;
        pos++;
        if (pos > 56) begin
            while (pos < 64) begin
                hash_block[pos] = 8'h00;
                pos++;
            end
            compress_hash_block();
            pos = 0;
        end
        while (pos < 56) begin
            hash_block[pos] = 8'h00;
            pos++;
        end
        for (int j = 0; j < 8; j++) begin
            hash_block[56+j] = bit_len[63-8*j -: 8];
        end
        compress_hash_block();
        for (int j = 0; j < 8; j++) begin
            item.word = hash_chain[j];
            item.idx  = t_widx'(j);
            item.last = (j == 7);
            digest_words_due.push_back(item);
        end
        hash_chain = HashInit;
        hash_len   = '0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                digest_if.ready <= 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
            end else begin
                digest_if.ready <= no_idle || ($urandom_range(99) >= 29);
                @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && digest_if.valid && digest_if.ready) begin
            if (digest_words_due.size() == 0) begin
                $display("%0t: digest word with none expected: actual %h index %0d",
                         $time, digest_if.digest_word, digest_if.word_index);
                mismatches++;
            end else begin
                due_item = digest_words_due.pop_front();
                words_checked++;
                if (digest_if.digest_word !== due_item.word) begin
                    $display("%0t: digest_word expected %h actual %h",
                             $time, due_item.word, digest_if.digest_word);
                    mismatches++;
                end
                if (digest_if.word_index !== due_item.idx) begin
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, due_item.idx, digest_if.word_index);
                    mismatches++;
                end
                if (digest_if.last_word !== due_item.last) begin
                    $display("%0t: last_word expected %b actual %b",
                             $time, due_item.last, digest_if.last_word);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((byte_if.valid && byte_if.ready) || (digest_if.valid && digest_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input t_byte b, input logic last);
        while (!no_idle && $urandom_range(99) < 29) begin
            byte_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.last_byte <= last;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        absorb_byte(b, last);
        bytes_sent++;
        if (last) begin
            messages_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(t_byte'($urandom_range(255)), i == len - 1);
        end
    endtask

    task automatic wait_for_digests();
        byte_if.valid <= 1'b0;
        while (digest_words_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_short_messages();
        no_idle = 1'b0;
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'ha5, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_block_boundaries();
        no_idle = 1'b1;
        send_message(56);
        send_message(64);
        no_idle = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hold_req = 1'b1;
        send_message(3);
        send_message(2);
    endtask

    task automatic test_drain_pause();
        send_message(4);
        wait_for_digests();
        send_message(3);
    endtask

    task automatic test_random_messages();
        int unsigned start_bytes;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < 10) begin
            send_message($urandom_range(6, 1));
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = '0;
        byte_if.last_byte = 1'b0;
        hash_chain        = HashInit;
        hash_len          = '0;
        mismatches        = 0;
        words_checked     = 0;
        messages_sent     = 0;
        bytes_sent        = 0;
        idle_cycles       = 0;
        no_idle           = 1'b0;
        hold_req          = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_short_messages();
        test_block_boundaries();
        test_output_backpressure();
        test_drain_pause();
        test_random_messages();

        wait_for_digests();
        repeat (TailCycles) @(posedge i_clk);
        if (digest_words_due.size() != 0) begin
            $display("%0t: %0d digest words never arrived", $time, digest_words_due.size());
            mismatches++;
        end
        $display("Hashed %0d messages of %0d bytes in total, including block-boundary lengths,",
                 messages_sent, bytes_sent);
        $display("a long output stall and a full drain; %0d digest words checked.",
                 words_checked);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
